@@ hdl/msc_pkg.sv @@
// Shared types and constants for the magnetometer sample calibrator.
// No dependencies; imported by every module of the block.
`default_nettype none

package msc_pkg;

    // raw sample layout
    localparam int RAW_W      = 18;   // code width delivered by the sensor
    localparam int CODE_MAX_W = 20;   // widest supported internal code
    localparam int BYTE_W     = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;
    localparam int ROW_CFG_W  = 48;
    localparam int BIAS_W     = 20;
    localparam int MAP_W      = 9;
    localparam int TSCALE_W   = 16;
    localparam int TOFFS_W    = 24;

    // result widths and saturation limits
    localparam int OUT_W    = 20;
    localparam int OUT_MAX  = 524287;
    localparam int OUT_MIN  = -524288;
    localparam int TEMP_W   = 25;
    localparam int TPROD_W  = BYTE_W + TSCALE_W;
    localparam int TEMP_MAX = 16777215;
    localparam int TEMP_MIN = -16777216;

    // reset values of the registers that do not depend on parameters
    localparam logic [MAP_W-1:0]    AXIS_MAP_RESET   = 9'd36;
    localparam logic [TSCALE_W-1:0] TEMP_SCALE_RESET = 16'd256;
    localparam logic [RAW_W-1:0]    ZERO_CODE_RESET  = 18'd131072;

    // select code for an output axis that takes no source
    localparam logic [1:0] SRC_NONE = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_FIRST   = 3'd0,
        CFG_ROW_SECOND  = 3'd1,
        CFG_ROW_THIRD   = 3'd2,
        CFG_BIAS        = 3'd3,
        CFG_AXIS_MAP    = 3'd4,
        CFG_TEMP_SCALE  = 3'd5,
        CFG_TEMP_OFFSET = 3'd6,
        CFG_ZERO_CODE   = 3'd7
    } msc_cfg_idx_t;

endpackage

`default_nettype wire

@@ hdl/msc_matrix_row.sv @@
// One soft-iron matrix row: three products, sum, round half up, saturate.
// Depends on msc_pkg for the result width and limits.
`default_nettype none

module msc_matrix_row #(
    parameter int COEF_BITS = 16,
    parameter int VEC_W     = 22
) (
    input  wire logic [3*COEF_BITS-1:0]       row,
    input  wire logic [3*VEC_W-1:0]           vec,
    output logic signed [msc_pkg::OUT_W-1:0] result
);
    import msc_pkg::*;

    localparam int FRAC_W = COEF_BITS - 2;
    localparam int PROD_W = COEF_BITS + VEC_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

    logic signed [COEF_BITS-1:0] coef [3];
    logic signed [VEC_W-1:0]     elem [3];
    logic signed [PROD_W-1:0]    prod [3];
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     scaled;

    // per-element products
    for (genvar k = 0; k < 3; k++) begin : g_prod
        assign coef[k] = $signed(row[k*COEF_BITS +: COEF_BITS]);
        assign elem[k] = $signed(vec[k*VEC_W +: VEC_W]);
        assign prod[k] = PROD_W'(coef[k]) * PROD_W'(elem[k]);
    end

    // sum with rounding bias, then floor shift gives round half up
    assign acc    = ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]) + HALF;
    assign scaled = acc >>> FRAC_W;

    // clamp to the result range
    always_comb begin
        priority if (scaled > SAT_HI) begin
            result = OUT_W'(SAT_HI);
        end else if (scaled < SAT_LO) begin
            result = OUT_W'(SAT_LO);
        end else begin
            result = scaled[OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hdl/magnetometer_sample_calibrator_top.sv @@
// Top level of the magnetometer sample calibrator.
// Depends on msc_pkg and msc_matrix_row.
`default_nettype none

// Calibrates one magnetometer sample per beat. Each input beat carries the
// eight raw sensor bytes; each output beat carries the hard/soft-iron
// corrected field and the scaled temperature. Throughput is one beat per
// clock unless m_ready stalls the output. An accepted beat passes the two
// register stages (unpack, axis map, bias subtract and temperature product
// into the first; 3x3 matrix multiply, temperature offset, rounding and
// saturation into the output register).
// Backpressure on m_ready stalls the pipeline; an empty stage still takes
// a new beat while the output register holds. Configuration writes take
// effect on the next cycle and should only be made while the block is idle.
module magnetometer_sample_calibrator_top #(
    parameter int SAMPLE_BITS = 18,
    parameter int COEF_BITS   = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [msc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [msc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // raw sample channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [msc_pkg::BYTE_W-1:0]          s_x_high_byte,
    input  wire logic [msc_pkg::BYTE_W-1:0]          s_x_mid_byte,
    input  wire logic [msc_pkg::BYTE_W-1:0]          s_y_high_byte,
    input  wire logic [msc_pkg::BYTE_W-1:0]          s_y_mid_byte,
    input  wire logic [msc_pkg::BYTE_W-1:0]          s_z_high_byte,
    input  wire logic [msc_pkg::BYTE_W-1:0]          s_z_mid_byte,
    input  wire logic [msc_pkg::BYTE_W-1:0]          s_low_bits_byte,
    input  wire logic [msc_pkg::BYTE_W-1:0]          s_raw_temperature,
    // calibrated result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [msc_pkg::OUT_W-1:0]         m_field_x,
    output logic signed [msc_pkg::OUT_W-1:0]         m_field_y,
    output logic signed [msc_pkg::OUT_W-1:0]         m_field_z,
    output logic signed [msc_pkg::TEMP_W-1:0]        m_temperature
);
    import msc_pkg::*;

    localparam int ROW_W  = (3 * COEF_BITS > ROW_CFG_W) ? 3 * COEF_BITS : ROW_CFG_W;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int VEC_W  = ((DIFF_W > BIAS_W) ? DIFF_W : BIAS_W) + 1;
    localparam int PAD_W  = CODE_MAX_W - RAW_W;
    localparam int TSUM_W = TPROD_W + 2;

    localparam logic [ROW_W-1:0] COEF_ONE   = ROW_W'(1) << (COEF_BITS - 2);
    localparam logic [ROW_W-1:0] ROW1_RESET = COEF_ONE;
    localparam logic [ROW_W-1:0] ROW2_RESET = COEF_ONE << COEF_BITS;
    localparam logic [ROW_W-1:0] ROW3_RESET = COEF_ONE << (2 * COEF_BITS);

    localparam logic signed [TSUM_W-1:0] TSAT_HI = TSUM_W'(TEMP_MAX);
    localparam logic signed [TSUM_W-1:0] TSAT_LO = TSUM_W'(TEMP_MIN);

    // configuration registers
    logic [ROW_W-1:0]          row1_reg, row2_reg, row3_reg;
    logic [CFG_DATA_W-1:0]     bias_reg;
    logic [MAP_W-1:0]          axis_map_reg;
    logic [TSCALE_W-1:0]       temp_scale_reg;
    logic signed [TOFFS_W-1:0] temp_offset_reg;
    logic [RAW_W-1:0]          zero_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row1_reg        <= ROW1_RESET;
            row2_reg        <= ROW2_RESET;
            row3_reg        <= ROW3_RESET;
            bias_reg        <= '0;
            axis_map_reg    <= AXIS_MAP_RESET;
            temp_scale_reg  <= TEMP_SCALE_RESET;
            temp_offset_reg <= '0;
            zero_code_reg   <= ZERO_CODE_RESET;
        end else if (cfg_wr_en) begin
            unique case (msc_cfg_idx_t'(cfg_index))
                CFG_ROW_FIRST:   row1_reg        <= ROW_W'(cfg_wdata[ROW_CFG_W-1:0]);
                CFG_ROW_SECOND:  row2_reg        <= ROW_W'(cfg_wdata[ROW_CFG_W-1:0]);
                CFG_ROW_THIRD:   row3_reg        <= ROW_W'(cfg_wdata[ROW_CFG_W-1:0]);
                CFG_BIAS:        bias_reg        <= cfg_wdata;
                CFG_AXIS_MAP:    axis_map_reg    <= cfg_wdata[MAP_W-1:0];
                CFG_TEMP_SCALE:  temp_scale_reg  <= cfg_wdata[TSCALE_W-1:0];
                CFG_TEMP_OFFSET: temp_offset_reg <= $signed(cfg_wdata[TOFFS_W-1:0]);
                CFG_ZERO_CODE:   zero_code_reg   <= cfg_wdata[RAW_W-1:0];
            endcase
        end
    end

    // pipeline flow control
    logic s1_valid_reg;
    logic s2_load;
    logic s1_load;

    assign s2_load = s1_valid_reg && (!m_valid || m_ready);
    assign s_ready = !s1_valid_reg || s2_load;
    assign s1_load = s_valid && s_ready;

    // unpack the three axis codes and rescale to the internal code width
    logic [RAW_W-1:0]        raw_x, raw_y, raw_z;
    logic [SAMPLE_BITS-1:0]  code_x, code_y, code_z;
    logic [SAMPLE_BITS-1:0]  zero_code;
    logic signed [DIFF_W-1:0] diff_x, diff_y, diff_z;

    assign raw_x = {s_x_high_byte, s_x_mid_byte, s_low_bits_byte[7:6]};
    assign raw_y = {s_y_high_byte, s_y_mid_byte, s_low_bits_byte[5:4]};
    assign raw_z = {s_z_high_byte, s_z_mid_byte, s_low_bits_byte[3:2]};

    assign code_x = SAMPLE_BITS'({raw_x, {PAD_W{1'b0}}} >> (CODE_MAX_W - SAMPLE_BITS));
    assign code_y = SAMPLE_BITS'({raw_y, {PAD_W{1'b0}}} >> (CODE_MAX_W - SAMPLE_BITS));
    assign code_z = SAMPLE_BITS'({raw_z, {PAD_W{1'b0}}} >> (CODE_MAX_W - SAMPLE_BITS));
    assign zero_code = SAMPLE_BITS'(zero_code_reg);

    assign diff_x = $signed({1'b0, code_x}) - $signed({1'b0, zero_code});
    assign diff_y = $signed({1'b0, code_y}) - $signed({1'b0, zero_code});
    assign diff_z = $signed({1'b0, code_z}) - $signed({1'b0, zero_code});

    // sensor frame to body frame: (-y, -x, z)
    logic signed [DIFF_W-1:0] src [3];

    assign src[0] = -diff_y;
    assign src[1] = -diff_x;
    assign src[2] = diff_z;

    // axis order, sign flip and hard-iron bias per output axis
    logic signed [DIFF_W-1:0] mapped [3];
    logic signed [VEC_W-1:0]  vec_next [3];

    for (genvar i = 0; i < 3; i++) begin : g_axis
        logic signed [DIFF_W-1:0] picked;
        logic signed [BIAS_W-1:0] bias;

        always_comb begin
            unique case (axis_map_reg[2*i +: 2])
                2'd0:     picked = src[0];
                2'd1:     picked = src[1];
                2'd2:     picked = src[2];
                SRC_NONE: picked = '0;
            endcase
        end

        assign mapped[i]   = axis_map_reg[6+i] ? -picked : picked;
        assign bias        = $signed(bias_reg[i*BIAS_W +: BIAS_W]);
        assign vec_next[i] = VEC_W'(mapped[i]) - VEC_W'(bias);
    end

    // first stage register
    logic [3*VEC_W-1:0]   vec_reg;
    logic [TPROD_W-1:0]   tprod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            vec_reg   <= {vec_next[2], vec_next[1], vec_next[0]};
            tprod_reg <= TPROD_W'(s_raw_temperature) * TPROD_W'(temp_scale_reg);
        end
    end

    // soft-iron matrix rows
    logic signed [OUT_W-1:0] field_next [3];

    msc_matrix_row #(
        .COEF_BITS (COEF_BITS),
        .VEC_W     (VEC_W)
    ) u_row_first (
        .row    (row1_reg[3*COEF_BITS-1:0]),
        .vec    (vec_reg),
        .result (field_next[0])
    );

    msc_matrix_row #(
        .COEF_BITS (COEF_BITS),
        .VEC_W     (VEC_W)
    ) u_row_second (
        .row    (row2_reg[3*COEF_BITS-1:0]),
        .vec    (vec_reg),
        .result (field_next[1])
    );

    msc_matrix_row #(
        .COEF_BITS (COEF_BITS),
        .VEC_W     (VEC_W)
    ) u_row_third (
        .row    (row3_reg[3*COEF_BITS-1:0]),
        .vec    (vec_reg),
        .result (field_next[2])
    );

    // temperature offset and clamp
    logic signed [TSUM_W-1:0] temp_sum;
    logic signed [TEMP_W-1:0] temp_next;

    assign temp_sum = $signed({2'b00, tprod_reg}) - TSUM_W'(temp_offset_reg);

    always_comb begin
        priority if (temp_sum > TSAT_HI) begin
            temp_next = TEMP_W'(TSAT_HI);
        end else if (temp_sum < TSAT_LO) begin
            temp_next = TEMP_W'(TSAT_LO);
        end else begin
            temp_next = temp_sum[TEMP_W-1:0];
        end
    end

    // output register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_load) begin
            m_field_x     <= field_next[0];
            m_field_y     <= field_next[1];
            m_field_z     <= field_next[2];
            m_temperature <= temp_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

@@ hdl/msc_checker.sv @@
// Port-level checks for the magnetometer sample calibrator.
// Depends on msc_pkg; bound to magnetometer_sample_calibrator_top below.
`default_nettype none

module msc_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [msc_pkg::OUT_W-1:0]         m_field_x,
    input wire logic [msc_pkg::OUT_W-1:0]         m_field_y,
    input wire logic [msc_pkg::OUT_W-1:0]         m_field_z,
    input wire logic [msc_pkg::TEMP_W-1:0]        m_temperature
);
    import msc_pkg::*;

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_field_x) && $stable(m_field_y)
            && $stable(m_field_z) && $stable(m_temperature)))
        else $error("result beat changed while stalled");

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side never blocked while the output side can drain
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with output free");

    // an accepted beat reaches the output once m_ready lets it leave the first stage
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind magnetometer_sample_calibrator_top msc_checker u_msc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_field_x     (m_field_x),
    .m_field_y     (m_field_y),
    .m_field_z     (m_field_z),
    .m_temperature (m_temperature)
);

`default_nettype wire
